/* design/mwm_pkg.sv */
// shared types and constants for the mecanum wheel mixer
// no dependencies; imported by every module of the block
`default_nettype none

package mwm_pkg;

    // motor limit after reset
    localparam logic [14:0] LIMIT_RESET = 15'd15000;

    // floor(n / 5) = (n * RECIP5) >> RECIP5_SHIFT, exact for n < 2**18
    localparam logic [15:0] RECIP5       = 16'd52429;
    localparam int          RECIP5_SHIFT = 18;

    // quotient bits of the desaturation divide (quotient <= motor limit < 2**15)
    localparam int QUO_BITS = 15;

    // one wheel sum, at most about 45900 in magnitude
    typedef logic signed [16:0] wheel_t;

    // result of the mixing stages
    typedef struct packed {
        wheel_t [3:0] w;
        logic [15:0]  m;
        logic         sat;
    } mix_item_t;

    // state carried through the divider stages
    typedef struct packed {
        logic [3:0][30:0] rem;
        logic [3:0][14:0] q;
        logic [3:0]       neg;
        wheel_t [3:0]     w;
        logic [15:0]      m;
        logic             sat;
    } div_item_t;

endpackage

`default_nettype wire

/* design/mwm_mix.sv */
// mixing stages: 4/5 rotation scale, four wheel sums, largest magnitude
// depends on mwm_pkg
`default_nettype none

module mwm_mix
    import mwm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic signed [14:0] speed_x,
    input  wire logic signed [14:0] speed_y,
    input  wire logic signed [14:0] speed_rot,
    input  wire logic [14:0]        motor_limit,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mix_item_t               out_item
);

    localparam int NS = 4;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;

    // stage 1 registers
    logic signed [14:0] s1_x_reg, s1_y_reg;
    logic               s1_neg_reg;
    logic [31:0]        s1_prod_reg;
    // stage 2 registers
    wheel_t [3:0]       s2_w_reg;
    // stage 3 registers
    wheel_t [3:0]       s3_w_reg;
    logic [15:0]        s3_max_a_reg, s3_max_b_reg;
    // stage 4 register
    mix_item_t          s4_item_reg;

    logic signed [15:0] rot_ext;
    logic [15:0]        rot_mag;
    logic [31:0]        s1_prod_next;

    wheel_t             x17, y17, rs_mag17, rs17;
    wheel_t [3:0]       s2_w_next;

    logic [3:0][15:0]   mag;
    logic [15:0]        s3_max_a_next, s3_max_b_next;

    logic [15:0]        m_all;
    mix_item_t          s4_item_next;

    // stall chain: a stage loads when it is empty or its successor loads
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    // stage 1: magnitude of rotation times four, times reciprocal of five
    always_comb begin
        rot_ext      = 16'(speed_rot);
        rot_mag      = rot_ext[15] ? 16'(-rot_ext) : 16'(rot_ext);
        s1_prod_next = 32'({rot_mag, 2'b00}) * 32'(RECIP5);
    end

    // stage 2: signed rotation term and the four wheel sums
    always_comb begin
        x17      = 17'(s1_x_reg);
        y17      = 17'(s1_y_reg);
        rs_mag17 = $signed({3'b000, s1_prod_reg[31:RECIP5_SHIFT]});
        rs17     = s1_neg_reg ? -rs_mag17 : rs_mag17;
        s2_w_next[0] =  x17 - y17 + rs17;
        s2_w_next[1] = -x17 - y17 + rs17;
        s2_w_next[2] = -x17 - y17 - rs17;
        s2_w_next[3] =  x17 - y17 - rs17;
    end

    // stage 3: magnitudes and pairwise maxima
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i] = s2_w_reg[i][16] ? 16'(-$signed(s2_w_reg[i])) : 16'(s2_w_reg[i]);
        end
        s3_max_a_next = (mag[1] > mag[0]) ? mag[1] : mag[0];
        s3_max_b_next = (mag[3] > mag[2]) ? mag[3] : mag[2];
    end

    // stage 4: overall maximum and saturation flag
    always_comb begin
        m_all            = (s3_max_b_reg > s3_max_a_reg) ? s3_max_b_reg : s3_max_a_reg;
        s4_item_next.w   = s3_w_reg;
        s4_item_next.m   = m_all;
        s4_item_next.sat = m_all > {1'b0, motor_limit};
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en[0]) begin
            s1_x_reg    <= speed_x;
            s1_y_reg    <= speed_y;
            s1_neg_reg  <= speed_rot[14];
            s1_prod_reg <= s1_prod_next;
        end
        if (en[1]) begin
            s2_w_reg <= s2_w_next;
        end
        if (en[2]) begin
            s3_w_reg     <= s2_w_reg;
            s3_max_a_reg <= s3_max_a_next;
            s3_max_b_reg <= s3_max_b_next;
        end
        if (en[3]) begin
            s4_item_reg <= s4_item_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_item  = s4_item_reg;

endmodule

`default_nettype wire

/* design/mwm_div.sv */
// desaturation: |w| * limit, then a restoring divide by the largest
// magnitude, one quotient bit per stage, four lanes; depends on mwm_pkg
`default_nettype none

module mwm_div
    import mwm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire mix_item_t   in_item,
    input  wire logic [14:0] motor_limit,
    output logic             out_valid,
    input  wire logic        out_ready,
    output div_item_t        out_item
);

    // one product stage, then one stage per quotient bit
    localparam int NS = 1 + QUO_BITS;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    div_item_t     stg_reg  [NS];
    div_item_t     stg_next [NS];

    logic [3:0][15:0] mag;

    // one restoring step on all four lanes for quotient bit b
    function automatic div_item_t div_step(input div_item_t d, input int b);
        div_item_t   r;
        logic [30:0] dsh;
        r   = d;
        dsh = 31'(d.m) << b;
        for (int i = 0; i < 4; i++) begin
            if (d.rem[i] >= dsh) begin
                r.rem[i]  = d.rem[i] - dsh;
                r.q[i][b] = 1'b1;
            end
        end
        return r;
    endfunction

    // stall chain
    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || out_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign in_ready = en[0];

    // product stage and bit stages
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mag[i] = in_item.w[i][16] ? 16'(-$signed(in_item.w[i])) : 16'(in_item.w[i]);
            stg_next[0].rem[i] = 31'(mag[i]) * 31'(motor_limit);
            stg_next[0].q[i]   = '0;
            stg_next[0].neg[i] = in_item.w[i][16];
        end
        stg_next[0].w   = in_item.w;
        stg_next[0].m   = in_item.m;
        stg_next[0].sat = in_item.sat;
        for (int k = 1; k < NS; k++) begin
            stg_next[k] = div_step(stg_reg[k-1], QUO_BITS - k);
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) vld_reg[0] <= in_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        for (int k = 0; k < NS; k++) begin
            if (en[k]) stg_reg[k] <= stg_next[k];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_item  = stg_reg[NS-1];

endmodule

`default_nettype wire

/* design/mecanum_wheel_mixer_top.sv */
// top level of the mecanum wheel mixer: limit register, mixing and
// divider pipelines, output register; depends on mwm_pkg, mwm_mix, mwm_div
//
//  channel   direction  payload (lowest bit first)
//  s_axis    in         speed_x, speed_y, speed_rot (15b signed each)
//  m_axis    out        left_front, left_back, right_front, right_back (16b)
//  cfg       in         motor_limit (15b unsigned)
//
// one command enters per cycle unless output back-pressure fills the pipe; 4 mixing stages,
// 1 product stage, 15 divider stages (one quotient bit each), 1 output register
// reset clears every valid bit and loads motor_limit with 15000
// a stage holds while its successor is full and stalled, so bubbles close up
// and s_tready drops only when every stage holds a command
`default_nettype none

module mecanum_wheel_mixer_top
    import mwm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // speed_x[14:0], speed_y[29:15], speed_rot[44:30], zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // left_front, left_back, right_front, right_back
    input  wire logic        cfg_we,
    input  wire logic [14:0] cfg_wdata
);

    logic [14:0] motor_limit_reg;

    logic        mix_valid, mix_ready;
    mix_item_t   mix_item;
    logic        div_valid, div_ready;
    div_item_t   div_item;

    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic [63:0] m_tdata_next;
    logic        out_en;

    logic signed [15:0] v [4];
    logic signed [15:0] qv;

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            motor_limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            motor_limit_reg <= cfg_wdata;
        end
    end

    mwm_mix u_mix (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .speed_x     ($signed(s_tdata[14:0])),
        .speed_y     ($signed(s_tdata[29:15])),
        .speed_rot   ($signed(s_tdata[44:30])),
        .motor_limit (motor_limit_reg),
        .out_valid   (mix_valid),
        .out_ready   (mix_ready),
        .out_item    (mix_item)
    );

    mwm_div u_div (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (mix_valid),
        .in_ready    (mix_ready),
        .in_item     (mix_item),
        .motor_limit (motor_limit_reg),
        .out_valid   (div_valid),
        .out_ready   (div_ready),
        .out_item    (div_item)
    );

    // output register loads when empty or when its transfer completes
    assign out_en    = !m_tvalid_reg || m_tready;
    assign div_ready = out_en;

    // pick scaled or raw speeds, restore signs, invert the right side
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            qv   = $signed({1'b0, div_item.q[i]});
            v[i] = div_item.sat ? (div_item.neg[i] ? -qv : qv) : 16'(div_item.w[i]);
        end
        m_tdata_next = {16'(-v[3]), 16'(-v[2]), v[1], v[0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_en) begin
            m_tvalid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_en) m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // input backpressure only when the whole pipe is full behind a stalled output
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while pipeline can still move");

    // outputs, scaled or raw, never reach the most negative code
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:0] != 16'h8000 && m_tdata[31:16] != 16'h8000 &&
                      m_tdata[47:32] != 16'h8000 && m_tdata[63:48] != 16'h8000))
        else $error("wheel speed out of range");

    // a command accepted into an empty pipe cannot appear at the output next cycle
    a_no_shortcut: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid && !div_valid) |=> !m_tvalid)
        else $error("result appeared without passing the divider");

endmodule

`default_nettype wire
